[rtl/rvdec_pkg.sv]
// rvdec_pkg: group codes, operation codes and decode tables for the rv64i decoder
// no dependencies; imported by rvdec_decode, rv64i_instruction_decoder_unit and its testbench

package rvdec_pkg;

  typedef enum logic [3:0] {
    GRP_LOAD     = 4'd0,
    GRP_STORE    = 4'd1,
    GRP_BRANCH   = 4'd2,
    GRP_JALR     = 4'd3,
    GRP_JAL      = 4'd4,
    GRP_OP_IMM   = 4'd5,
    GRP_OP       = 4'd6,
    GRP_SYSTEM   = 4'd7,
    GRP_AUIPC    = 4'd8,
    GRP_LUI      = 4'd9,
    GRP_OP_IMM32 = 4'd10,
    GRP_OP32     = 4'd11
  } grp_t;

  typedef logic [5:0] op_t;

  localparam op_t OP_LB = 6'd0, OP_LH = 6'd1, OP_LW = 6'd2, OP_LD = 6'd3;
  localparam op_t OP_LBU = 6'd4, OP_LHU = 6'd5, OP_LWU = 6'd6;
  localparam op_t OP_SB = 6'd7, OP_SH = 6'd8, OP_SW = 6'd9, OP_SD = 6'd10;
  localparam op_t OP_BEQ = 6'd11, OP_BNE = 6'd12, OP_BLT = 6'd13, OP_BGE = 6'd14;
  localparam op_t OP_BLTU = 6'd15, OP_BGEU = 6'd16;
  localparam op_t OP_JALR = 6'd17, OP_JAL = 6'd18;
  localparam op_t OP_ADDI = 6'd19, OP_SLLI = 6'd20, OP_SLTI = 6'd21, OP_SLTIU = 6'd22;
  localparam op_t OP_XORI = 6'd23, OP_SRLI = 6'd24, OP_ORI = 6'd25, OP_ANDI = 6'd26;
  localparam op_t OP_SRAI = 6'd27;
  localparam op_t OP_ADD = 6'd28, OP_SLL = 6'd29, OP_SLT = 6'd30, OP_SLTU = 6'd31;
  localparam op_t OP_XOR = 6'd32, OP_SRL = 6'd33, OP_OR = 6'd34, OP_AND = 6'd35;
  localparam op_t OP_SUB = 6'd36, OP_SRA = 6'd37;
  localparam op_t OP_ECALL = 6'd38, OP_EBREAK = 6'd39, OP_URET = 6'd40;
  localparam op_t OP_SRET = 6'd41, OP_MRET = 6'd42, OP_WFI = 6'd43;
  localparam op_t OP_CSRRW = 6'd44, OP_CSRRS = 6'd45, OP_CSRRC = 6'd46;
  localparam op_t OP_CSRRWI = 6'd47, OP_CSRRSI = 6'd48, OP_CSRRCI = 6'd49;
  localparam op_t OP_AUIPC = 6'd50, OP_LUI = 6'd51;
  localparam op_t OP_ADDIW = 6'd52, OP_SLLIW = 6'd53, OP_SRLIW = 6'd54, OP_SRAIW = 6'd55;
  localparam op_t OP_ADDW = 6'd56, OP_SLLW = 6'd57, OP_SRLW = 6'd58, OP_SUBW = 6'd59;
  localparam op_t OP_SRAW = 6'd60;
  localparam op_t OP_SYS_NOP = 6'd61;
  localparam op_t OP_NONE = 6'd0;

  // funct12 codes under system funct3 0
  localparam logic [11:0] F12_ECALL  = 12'h000;
  localparam logic [11:0] F12_EBREAK = 12'h001;
  localparam logic [11:0] F12_URET   = 12'h002;
  localparam logic [11:0] F12_SRET   = 12'h102;
  localparam logic [11:0] F12_MRET   = 12'h302;
  localparam logic [11:0] F12_WFI    = 12'h105;

  localparam logic [2:0] F3_SHR  = 3'd5;
  localparam logic [2:0] F3_PRIV = 3'd0;

  typedef struct packed {
    logic valid;
    grp_t grp;
  } grp_lookup_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_lookup_t;

  typedef struct packed {
    grp_t grp;
    op_t  op;
    logic illegal;
  } dec_result_t;

  // major group from opcode bits 4:2 and 6:5
  function automatic grp_lookup_t group_of(input logic [2:0] lo, input logic [1:0] hi);
    grp_lookup_t r;
    r.valid = 1'b1;
    r.grp   = GRP_LOAD;
    case ({lo, hi})
      {3'd0, 2'd0}: r.grp = GRP_LOAD;
      {3'd0, 2'd1}: r.grp = GRP_STORE;
      {3'd0, 2'd3}: r.grp = GRP_BRANCH;
      {3'd1, 2'd3}: r.grp = GRP_JALR;
      {3'd3, 2'd3}: r.grp = GRP_JAL;
      {3'd4, 2'd0}: r.grp = GRP_OP_IMM;
      {3'd4, 2'd1}: r.grp = GRP_OP;
      {3'd4, 2'd3}: r.grp = GRP_SYSTEM;
      {3'd5, 2'd0}: r.grp = GRP_AUIPC;
      {3'd5, 2'd1}: r.grp = GRP_LUI;
      {3'd6, 2'd0}: r.grp = GRP_OP_IMM32;
      {3'd6, 2'd1}: r.grp = GRP_OP32;
      default:      r.valid = 1'b0;
    endcase
    return r;
  endfunction

  function automatic op_lookup_t mk(input op_t op);
    op_lookup_t r;
    r.valid = 1'b1;
    r.op    = op;
    return r;
  endfunction

  // operation within a group; idx is {bit 30 where it counts, funct3}
  function automatic op_lookup_t op_of(input grp_t grp, input logic [3:0] idx);
    op_lookup_t r;
    r.valid = 1'b0;
    r.op    = OP_NONE;
    case (grp)
      GRP_LOAD: begin
        case (idx)
          4'd0: r = mk(OP_LB);   4'd1: r = mk(OP_LH);  4'd2: r = mk(OP_LW);
          4'd3: r = mk(OP_LD);   4'd4: r = mk(OP_LBU); 4'd5: r = mk(OP_LHU);
          4'd6: r = mk(OP_LWU);
          default: r.valid = 1'b0;
        endcase
      end
      GRP_STORE: begin
        case (idx)
          4'd0: r = mk(OP_SB); 4'd1: r = mk(OP_SH);
          4'd2: r = mk(OP_SW); 4'd3: r = mk(OP_SD);
          default: r.valid = 1'b0;
        endcase
      end
      GRP_BRANCH: begin
        case (idx)
          4'd0: r = mk(OP_BEQ);  4'd1: r = mk(OP_BNE);
          4'd4: r = mk(OP_BLT);  4'd5: r = mk(OP_BGE);
          4'd6: r = mk(OP_BLTU); 4'd7: r = mk(OP_BGEU);
          default: r.valid = 1'b0;
        endcase
      end
      GRP_JALR: begin
        case (idx)
          4'd0:    r = mk(OP_JALR);
          default: r.valid = 1'b0;
        endcase
      end
      GRP_JAL: begin
        if (!idx[3]) r = mk(OP_JAL);
      end
      GRP_OP_IMM: begin
        case (idx)
          4'd0:  r = mk(OP_ADDI);  4'd1: r = mk(OP_SLLI); 4'd2: r = mk(OP_SLTI);
          4'd3:  r = mk(OP_SLTIU); 4'd4: r = mk(OP_XORI); 4'd5: r = mk(OP_SRLI);
          4'd6:  r = mk(OP_ORI);   4'd7: r = mk(OP_ANDI);
          4'd13: r = mk(OP_SRAI);
          default: r.valid = 1'b0;
        endcase
      end
      GRP_OP: begin
        case (idx)
          4'd0:  r = mk(OP_ADD); 4'd1: r = mk(OP_SLL); 4'd2: r = mk(OP_SLT);
          4'd3:  r = mk(OP_SLTU); 4'd4: r = mk(OP_XOR); 4'd5: r = mk(OP_SRL);
          4'd6:  r = mk(OP_OR);  4'd7: r = mk(OP_AND); 4'd8: r = mk(OP_SUB);
          4'd13: r = mk(OP_SRA);
          default: r.valid = 1'b0;
        endcase
      end
      GRP_SYSTEM: begin
        case (idx)
          4'd0: r = mk(OP_ECALL);  4'd1: r = mk(OP_CSRRW);  4'd2: r = mk(OP_CSRRS);
          4'd3: r = mk(OP_CSRRC);  4'd5: r = mk(OP_CSRRWI); 4'd6: r = mk(OP_CSRRSI);
          4'd7: r = mk(OP_CSRRCI);
          default: r.valid = 1'b0;
        endcase
      end
      GRP_AUIPC: begin
        if (!idx[3]) r = mk(OP_AUIPC);
      end
      GRP_LUI: begin
        if (!idx[3]) r = mk(OP_LUI);
      end
      GRP_OP_IMM32: begin
        case (idx)
          4'd0:  r = mk(OP_ADDIW); 4'd1: r = mk(OP_SLLIW);
          4'd5:  r = mk(OP_SRLIW); 4'd13: r = mk(OP_SRAIW);
          default: r.valid = 1'b0;
        endcase
      end
      GRP_OP32: begin
        case (idx)
          4'd0:  r = mk(OP_ADDW); 4'd1: r = mk(OP_SLLW); 4'd5: r = mk(OP_SRLW);
          4'd8:  r = mk(OP_SUBW); 4'd13: r = mk(OP_SRAW);
          default: r.valid = 1'b0;
        endcase
      end
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

  // privileged instruction under system funct3 0
  function automatic op_t priv_of(input logic [11:0] f12);
    op_t r;
    case (f12)
      F12_ECALL:  r = OP_ECALL;
      F12_EBREAK: r = OP_EBREAK;
      F12_URET:   r = OP_URET;
      F12_SRET:   r = OP_SRET;
      F12_MRET:   r = OP_MRET;
      F12_WFI:    r = OP_WFI;
      default:    r = OP_SYS_NOP;
    endcase
    return r;
  endfunction

endpackage

[rtl/rv64i_instruction_decoder_unit.sv]
// rv64i_instruction_decoder_unit: registered rv64i decoder, one item per cycle
// start is registered in the input stage, and done in the result stage from its valid
// throughput: one item every cycle; busy is never raised, set by the single decode pass
// results are strobed for one cycle on done and cannot be held off by the receiver
// reset: synchronous active-high rst empties both stages; no item is in flight after it
// depends on rvdec_pkg and rvdec_decode

module rv64i_instruction_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] instruction,
  output logic        done,
  output logic [3:0]  major_group,
  output logic [5:0]  operation,
  output logic        illegal
);
  import rvdec_pkg::*;

  // input stage
  logic        in_valid;
  logic [31:0] in_word;

  // decode result between the stages
  dec_result_t dec;

  // result stage
  dec_result_t out_res;

  // the decode is a single shallow pass, so a new item is always welcome
  assign busy = 1'b0;

  // input register: valid is control, the word is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_word <= instruction;
    end
  end

  rvdec_decode u_decode (
    .word (in_word),
    .res  (dec)
  );

  // result register: strobe for exactly one cycle per item
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_res <= dec;
    end
  end

  assign major_group = out_res.grp;
  assign operation   = out_res.op;
  assign illegal     = out_res.illegal;

  // every result traces back to a start taken through the input and result registers
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("result strobe without a matching start");

  // an illegal item never carries an operation
  a_illegal_no_op: assert property (@(posedge clk) disable iff (rst)
    (done && illegal) |-> (operation == OP_NONE))
    else $error("illegal item carries an operation");

  // the no-effect system code only comes out of the system group
  a_sys_nop_group: assert property (@(posedge clk) disable iff (rst)
    (done && operation == OP_SYS_NOP) |-> (major_group == GRP_SYSTEM && !illegal))
    else $error("system no-effect code outside the system group");

  // a legal item always names a real group
  a_legal_group: assert property (@(posedge clk) disable iff (rst)
    (done && !illegal) |-> (major_group <= GRP_OP32))
    else $error("legal item with an out-of-range group");

endmodule

[rtl/rvdec_decode.sv]
// rvdec_decode: combinational decode of one instruction word
// depends on rvdec_pkg (tables and result struct)

module rvdec_decode (
  input  logic [31:0]               word,
  output rvdec_pkg::dec_result_t    res
);
  import rvdec_pkg::*;

  grp_lookup_t g;
  op_lookup_t  o;
  logic [2:0]  f3;
  logic        use_b30;
  logic [3:0]  idx;

  assign f3 = word[14:12];
  assign g  = group_of(word[4:2], word[6:5]);

  // bit 30 extends the index for register ops and right shifts
  assign use_b30 = (g.grp == GRP_OP) || (g.grp == GRP_OP32) ||
                   (((g.grp == GRP_OP_IMM) || (g.grp == GRP_OP_IMM32)) && (f3 == F3_SHR));
  assign idx = {use_b30 & word[30], f3};
  assign o   = op_of(g.grp, idx);

  always_comb begin
    res.grp     = GRP_LOAD;
    res.op      = OP_NONE;
    res.illegal = 1'b1;
    if (g.valid) begin
      res.grp = g.grp;
      if (o.valid) begin
        res.illegal = 1'b0;
        if (g.grp == GRP_SYSTEM && f3 == F3_PRIV) begin
          res.op = priv_of(word[31:20]);
        end else begin
          res.op = o.op;
        end
      end
    end
  end

endmodule

[tb/sv/rv64i_instruction_decoder_unit_tb.sv]
// rv64i_instruction_decoder_unit_tb: self-checking testbench for the rv64i decoder unit
// drives instruction words through the start/busy handshake, predicts each decode and
// checks every done strobe in order; depends on rvdec_pkg and rv64i_instruction_decoder_unit
`timescale 1ns / 1ps

module rv64i_instruction_decoder_unit_tb;
  import rvdec_pkg::*;

  // opcode bits 6:2 of each major group
  localparam logic [4:0] OPC_LOAD     = 5'b00_000;
  localparam logic [4:0] OPC_STORE    = 5'b01_000;
  localparam logic [4:0] OPC_BRANCH   = 5'b11_000;
  localparam logic [4:0] OPC_JALR     = 5'b11_001;
  localparam logic [4:0] OPC_JAL      = 5'b11_011;
  localparam logic [4:0] OPC_OP_IMM   = 5'b00_100;
  localparam logic [4:0] OPC_OP       = 5'b01_100;
  localparam logic [4:0] OPC_SYSTEM   = 5'b11_100;
  localparam logic [4:0] OPC_AUIPC    = 5'b00_101;
  localparam logic [4:0] OPC_LUI      = 5'b01_101;
  localparam logic [4:0] OPC_OP_IMM32 = 5'b00_110;
  localparam logic [4:0] OPC_OP32     = 5'b01_110;

  typedef struct packed {
    grp_t group;
    op_t  op;
    logic illegal;
  } decode_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] instruction;
  logic        done;
  logic [3:0]  major_group;
  logic [5:0]  operation;
  logic        illegal;

  decode_t     pending_decodes[$];
  int unsigned decode_errors = 0;
  bit          full_rate     = 1'b0;
  int unsigned calm_left     = 0;

  rv64i_instruction_decoder_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .instruction (instruction),
    .done        (done),
    .major_group (major_group),
    .operation   (operation),
    .illegal     (illegal)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected decode of one instruction word
  function automatic decode_t predict_decode(input logic [31:0] w);
    decode_t    d;
    logic [2:0] f3;
    logic [3:0] slot;
    logic       hit;
    f3        = w[14:12];
    d.group   = GRP_LOAD;
    d.op      = OP_NONE;
    d.illegal = 1'b1;
    hit       = 1'b1;
    // bits 1:0 play no part in the group
    case (w[6:2])
      OPC_LOAD:     d.group = GRP_LOAD;
      OPC_STORE:    d.group = GRP_STORE;
      OPC_BRANCH:   d.group = GRP_BRANCH;
      OPC_JALR:     d.group = GRP_JALR;
      OPC_JAL:      d.group = GRP_JAL;
      OPC_OP_IMM:   d.group = GRP_OP_IMM;
      OPC_OP:       d.group = GRP_OP;
      OPC_SYSTEM:   d.group = GRP_SYSTEM;
      OPC_AUIPC:    d.group = GRP_AUIPC;
      OPC_LUI:      d.group = GRP_LUI;
      OPC_OP_IMM32: d.group = GRP_OP_IMM32;
      OPC_OP32:     d.group = GRP_OP32;
      default:      hit = 1'b0;
    endcase
    // empty opcode slot: group stays load, operation zero, flagged
    if (!hit) return d;
    // bit 30 widens the slot for register ops and for right shifts by immediate
    if (d.group == GRP_OP || d.group == GRP_OP32 ||
        ((d.group == GRP_OP_IMM || d.group == GRP_OP_IMM32) && f3 == F3_SHR))
      slot = {w[30], f3};
    else
      slot = {1'b0, f3};
    case (d.group)
      GRP_LOAD: begin
        hit  = (slot < 4'd7);
        d.op = OP_LB + 6'(slot);
      end
      GRP_STORE: begin
        hit  = (slot < 4'd4);
        d.op = OP_SB + 6'(slot);
      end
      GRP_BRANCH: begin
        if (slot == 4'd0) d.op = OP_BEQ;
        else if (slot == 4'd1) d.op = OP_BNE;
        else if (slot >= 4'd4 && slot <= 4'd7) d.op = OP_BLT + 6'(slot - 4'd4);
        else hit = 1'b0;
      end
      GRP_JALR: begin
        hit  = (slot == 4'd0);
        d.op = OP_JALR;
      end
      GRP_JAL:   d.op = OP_JAL;
      GRP_AUIPC: d.op = OP_AUIPC;
      GRP_LUI:   d.op = OP_LUI;
      GRP_OP_IMM: begin
        if (slot < 4'd8) d.op = OP_ADDI + 6'(slot);
        else if (slot == {1'b1, F3_SHR}) d.op = OP_SRAI;
        else hit = 1'b0;
      end
      GRP_OP: begin
        if (slot < 4'd8) d.op = OP_ADD + 6'(slot);
        else if (slot == 4'd8) d.op = OP_SUB;
        else if (slot == {1'b1, F3_SHR}) d.op = OP_SRA;
        else hit = 1'b0;
      end
      GRP_SYSTEM: begin
        if (slot == {1'b0, F3_PRIV}) begin
          // privileged group picked by funct12; anything else is a harmless no-op
          case (w[31:20])
            F12_ECALL:  d.op = OP_ECALL;
            F12_EBREAK: d.op = OP_EBREAK;
            F12_URET:   d.op = OP_URET;
            F12_SRET:   d.op = OP_SRET;
            F12_MRET:   d.op = OP_MRET;
            F12_WFI:    d.op = OP_WFI;
            default:    d.op = OP_SYS_NOP;
          endcase
        end else if (slot >= 4'd1 && slot <= 4'd3) d.op = OP_CSRRW + 6'(slot - 4'd1);
        else if (slot >= 4'd5 && slot <= 4'd7) d.op = OP_CSRRWI + 6'(slot - 4'd5);
        else hit = 1'b0;
      end
      GRP_OP_IMM32: begin
        if (slot == 4'd0) d.op = OP_ADDIW;
        else if (slot == 4'd1) d.op = OP_SLLIW;
        else if (slot == {1'b0, F3_SHR}) d.op = OP_SRLIW;
        else if (slot == {1'b1, F3_SHR}) d.op = OP_SRAIW;
        else hit = 1'b0;
      end
      GRP_OP32: begin
        if (slot == 4'd0) d.op = OP_ADDW;
        else if (slot == 4'd1) d.op = OP_SLLW;
        else if (slot == {1'b0, F3_SHR}) d.op = OP_SRLW;
        else if (slot == 4'd8) d.op = OP_SUBW;
        else if (slot == {1'b1, F3_SHR}) d.op = OP_SRAW;
        else hit = 1'b0;
      end
      default: hit = 1'b0;
    endcase
    // empty function slot keeps the decoded group but zeroes the operation
    if (!hit) d.op = OP_NONE;
    d.illegal = ~hit;
    return d;
  endfunction

  // results are compared before the item accepted on the same edge is queued
  always @(posedge clk) begin
    decode_t exp_dec;
    if (!rst) begin
      if (done) begin
        if (pending_decodes.size() == 0) begin
          $display("%0t: done with no decode pending (group %0d op %0d illegal %0b)",
                   $time, major_group, operation, illegal);
          decode_errors++;
        end else begin
          exp_dec = pending_decodes.pop_front();
          if (major_group !== exp_dec.group) begin
            $display("%0t: major_group expected %0d actual %0d",
                     $time, exp_dec.group, major_group);
            decode_errors++;
          end
          if (operation !== exp_dec.op) begin
            $display("%0t: operation expected %0d actual %0d",
                     $time, exp_dec.op, operation);
            decode_errors++;
          end
          if (illegal !== exp_dec.illegal) begin
            $display("%0t: illegal expected %0b actual %0b",
                     $time, exp_dec.illegal, illegal);
            decode_errors++;
          end
        end
      end
      if (start && !busy) pending_decodes.push_back(predict_decode(instruction));
    end
  end

  // one item through the handshake; entered and left at a falling edge
  task automatic send_item(input logic [31:0] w);
    int unsigned gap;
    if (full_rate) begin
      gap = 0;
    end else if (calm_left != 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      // a stretch of back-to-back items
      calm_left = $urandom_range(5, 30);
      gap       = 0;
    end else begin
      gap = $urandom_range(0, 18);
    end
    if (gap != 0) begin
      start       <= 1'b0;
      instruction <= $urandom;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    instruction <= w;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // extremes, empty slots, bit 30 rules and the funct3-blind groups
  task automatic test_corner_words();
    send_item(32'h0000_0000);   // all zero: lb
    send_item(32'hFFFF_FFFF);   // all ones: empty opcode slot
    send_item(32'h0000_002B);   // empty opcode slot with other bits clear
    send_item(32'hFFFF_FF7C);   // empty opcode slot, bits 1:0 clear
    send_item(32'h0000_7003);   // load funct3 7: empty function slot
    send_item(32'h0000_4023);   // store funct3 4: empty function slot
    send_item(32'h0000_2063);   // branch funct3 2: empty function slot
    send_item(32'h0000_1067);   // jalr funct3 1: empty function slot
    send_item(32'h4000_706F);   // jal ignores funct3 and bit 30
    send_item(32'h4000_5017);   // auipc ignores funct3 and bit 30
    send_item(32'hFFFF_FFB7);   // lui with every other bit set
    send_item(32'h4000_1013);   // slli: bit 30 not joined for funct3 1
    send_item(32'h0000_5013);   // srli
    send_item(32'h4000_5013);   // srai
    send_item(32'h4000_0033);   // sub
    send_item(32'h4000_5033);   // sra
    send_item(32'h4000_1033);   // op with bit 30 on funct3 1: empty slot
    send_item(32'h4000_001B);   // addiw: bit 30 ignored for funct3 0
    send_item(32'h4000_501B);   // sraiw
    send_item(32'h4000_003B);   // subw
    send_item(32'h4000_103B);   // op32 with bit 30 on funct3 1: empty slot
  endtask

  // funct12 decode under system funct3 0 and the empty csr slot
  task automatic test_system_functions();
    send_item({F12_ECALL, 13'd0, OPC_SYSTEM, 2'b11});
    send_item({F12_EBREAK, 13'd0, OPC_SYSTEM, 2'b11});
    send_item({F12_URET, 13'd0, OPC_SYSTEM, 2'b11});
    send_item({F12_SRET, 13'd0, OPC_SYSTEM, 2'b11});
    send_item({F12_MRET, 13'd0, OPC_SYSTEM, 2'b11});
    send_item({F12_WFI, 13'd0, OPC_SYSTEM, 2'b11});
    send_item(32'hFFF0_0073);   // unknown funct12: no-op, legal
    send_item(32'h0000_4073);   // system funct3 4: empty slot
  endtask

  // mostly well-formed words of a random group with random content, the rest noise
  task automatic test_random_words(input int unsigned count);
    logic [31:0] w;
    for (int unsigned i = 0; i < count; i++) begin
      w = $urandom;
      if ($urandom_range(0, 99) < 75) begin
        case ($urandom_range(0, 11))
          0:  w[6:2] = OPC_LOAD;
          1:  w[6:2] = OPC_STORE;
          2:  w[6:2] = OPC_BRANCH;
          3:  w[6:2] = OPC_JALR;
          4:  w[6:2] = OPC_JAL;
          5:  w[6:2] = OPC_OP_IMM;
          6:  w[6:2] = OPC_OP;
          7:  w[6:2] = OPC_SYSTEM;
          8:  w[6:2] = OPC_AUIPC;
          9:  w[6:2] = OPC_LUI;
          10: w[6:2] = OPC_OP_IMM32;
          default: w[6:2] = OPC_OP32;
        endcase
        // steer system words towards the privileged decode
        if (w[6:2] == OPC_SYSTEM && $urandom_range(0, 2) == 0) w[14:12] = F3_PRIV;
        if (w[6:2] == OPC_SYSTEM && w[14:12] == F3_PRIV && $urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 5))
            0: w[31:20] = F12_ECALL;
            1: w[31:20] = F12_EBREAK;
            2: w[31:20] = F12_URET;
            3: w[31:20] = F12_SRET;
            4: w[31:20] = F12_MRET;
            default: w[31:20] = F12_WFI;
          endcase
        end
      end
      send_item(w);
    end
  endtask

  // one item every cycle with no gaps at all
  task automatic test_full_rate(input int unsigned count);
    full_rate = 1'b1;
    test_random_words(count);
    full_rate = 1'b0;
  endtask

  initial begin
    int unsigned drain;
    rst         = 1'b1;
    start       = 1'b0;
    instruction = 32'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_corner_words();
    test_system_functions();
    test_random_words(700);
    test_full_rate(150);

    start <= 1'b0;
    // wait for the last decodes, then keep watching for any stray strobe
    drain = 0;
    while (pending_decodes.size() != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    repeat (6) @(posedge clk);
    if (pending_decodes.size() != 0) begin
      $display("%0t: %0d decodes expected but never strobed", $time, pending_decodes.size());
      decode_errors++;
    end
    if (decode_errors == 0) begin
      $display("rv64i_instruction_decoder_unit verification clean");
    end else begin
      $display("rv64i_instruction_decoder_unit verification failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("rv64i_instruction_decoder_unit verification failed");
    $finish;
  end

endmodule
